// ----- rtl/lees_pkg.sv -----
// Package for the line edge equation setup block.
// Holds the datapath widths, the carried payload type and the output saturation.
// No dependencies.
package lees_pkg;

  localparam int CoordW  = 24;
  localparam int DiffW   = CoordW + 1;
  localparam int SumW    = CoordW + 2;
  localparam int ProdW   = 2 * CoordW;
  localparam int PW      = 2 * CoordW + 2;
  localparam int NW      = PW;
  localparam int LenFrac = 8;
  localparam int SqW     = 2 * DiffW + LenFrac;
  localparam int RootW   = SqW / 2;
  localparam int DW      = SumW + RootW;
  localparam int QW      = 33;
  localparam int OutW    = 32;
  localparam int TermW   = QW + 2;
  localparam int Lanes   = 5;
  localparam int AlongF  = 29;
  localparam int EdgeF   = 21;

  localparam logic [QW-1:0] MagCap = {1'b1, {(QW - 1){1'b0}}};
  localparam logic signed [TermW-1:0] SatMax  = 35'sh0_7FFF_FFFF;
  localparam logic signed [TermW-1:0] SatMin  = -35'sh0_8000_0000;
  localparam logic signed [TermW-1:0] OneQ16  = 35'sd65536;

  typedef struct packed {
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
    logic [SumW-1:0]         s;
    logic signed [PW-1:0]    p0;
    logic signed [PW-1:0]    p1;
    logic signed [PW-1:0]    p3;
  } lees_carry_t;

  // Applies the sign, the optional 1.0 offset and 32-bit saturation.
  function automatic logic [OutW-1:0] lees_term(input logic [QW-1:0] mag, input logic neg,
                                                input logic add_one);
    logic signed [TermW-1:0] v;
    v = $signed({2'b00, mag});
    if (neg) begin
      v = -v;
    end
    if (add_one) begin
      v = v + OneQ16;
    end
    if (v > SatMax) begin
      v = SatMax;
    end else if (v < SatMin) begin
      v = SatMin;
    end
    return v[OutW-1:0];
  endfunction

endpackage

// ----- rtl/line_edge_equation_setup.sv -----
// Channel   Dir  tdata fields (low bit first)                          tuser
// s_axis    in   start_x, start_y, end_x, end_y, line_width,           -
//                sample_radius (6 x 24 bits)
// m_axis    out  along_x_term, along_y_term, edge0_const ... edge3_const  degenerate
//                (6 x 32 bits)
//
// One segment is accepted every cycle while the pipeline advances; a stalled output holds it.
// The pipeline holds the 29-stage square root and the 33-stage divider lanes.
// Reset clears only the valid bits of the pipeline and the output register.
// The pipeline advances whenever the output register is free or its last stage is empty.
// Top level of the line edge equation setup pipeline; uses lees_pkg.
module line_edge_equation_setup
  import lees_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // start_x, start_y, end_x, end_y, line_width, sample_radius
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // along_x_term, along_y_term, edge0_const, edge1_const, edge2_const, edge3_const
  output logic [191:0] m_axis_tdata,
  // degenerate
  output logic         m_axis_tuser
);

  logic outgo, adv;

  logic signed [CoordW-1:0] in_x0, in_y0, in_x1, in_y1;
  logic [CoordW-1:0] in_w, in_r;

  logic a_valid;
  logic signed [DiffW-1:0] a_dx, a_dy;
  logic [SumW-1:0] a_s;
  logic signed [ProdW-1:0] a_x0y1, a_x1y0, a_x0x0, a_y0y0, a_x0x1, a_y0y1, a_x1x1, a_y1y1;

  logic b_valid;
  lees_carry_t b_car;
  logic [2*DiffW-1:0] b_dxx, b_dyy;

  logic sq_valid [RootW+1];
  lees_carry_t sq_car [RootW+1];
  logic [SqW-1:0] sq_rem [RootW+1];
  logic [RootW-1:0] sq_root [RootW+1];

  logic e_valid, e_degen;
  lees_carry_t e_car;
  logic [DW-1:0] e_d;

  logic [NW-1:0] lane_num [Lanes];
  logic lane_neg [Lanes];

  logic dv_valid [QW+1];
  logic dv_degen [QW+1];
  logic [DW-1:0] dv_d [QW+1];
  logic [DW-1:0] dv_rem [QW+1][Lanes];
  logic [QW-1:0] dv_q [QW+1][Lanes];
  logic [QW-1:0] dv_low [QW+1][Lanes];
  logic dv_ovf [QW+1][Lanes];
  logic dv_neg [QW+1][Lanes];

  logic [QW-1:0] fin_mag [Lanes];

  assign outgo = !m_axis_tvalid || m_axis_tready;
  assign adv = outgo || !dv_valid[QW];
  assign s_axis_tready = adv;

  assign in_x0 = $signed(s_axis_tdata[23:0]);
  assign in_y0 = $signed(s_axis_tdata[47:24]);
  assign in_x1 = $signed(s_axis_tdata[71:48]);
  assign in_y1 = $signed(s_axis_tdata[95:72]);
  assign in_w  = s_axis_tdata[119:96];
  assign in_r  = s_axis_tdata[143:120];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      sq_valid[0] <= 1'b0;
      e_valid <= 1'b0;
      dv_valid[0] <= 1'b0;
    end else if (adv) begin
      a_valid <= s_axis_tvalid;
      b_valid <= a_valid;
      sq_valid[0] <= b_valid;
      e_valid <= sq_valid[RootW];
      dv_valid[0] <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_dx   <= DiffW'(in_x1) - DiffW'(in_x0);
      a_dy   <= DiffW'(in_y1) - DiffW'(in_y0);
      a_s    <= {1'b0, in_r, 1'b0} + {2'b00, in_w};
      a_x0y1 <= in_x0 * in_y1;
      a_x1y0 <= in_x1 * in_y0;
      a_x0x0 <= in_x0 * in_x0;
      a_y0y0 <= in_y0 * in_y0;
      a_x0x1 <= in_x0 * in_x1;
      a_y0y1 <= in_y0 * in_y1;
      a_x1x1 <= in_x1 * in_x1;
      a_y1y1 <= in_y1 * in_y1;

      b_car.dx <= a_dx;
      b_car.dy <= a_dy;
      b_car.s  <= a_s;
      b_car.p0 <= PW'(a_x0y1) - PW'(a_x1y0);
      b_car.p1 <= PW'(a_x0x0) + PW'(a_y0y0) - PW'(a_x0x1) - PW'(a_y0y1);
      b_car.p3 <= PW'(a_x1x1) + PW'(a_y1y1) - PW'(a_x0x1) - PW'(a_y0y1);
      b_dxx <= a_dx * a_dx;
      b_dyy <= a_dy * a_dy;

      sq_car[0]  <= b_car;
      sq_rem[0]  <= {b_dxx + b_dyy, {LenFrac{1'b0}}};
      sq_root[0] <= '0;

      e_car   <= sq_car[RootW];
      e_d     <= sq_root[RootW] * sq_car[RootW].s;
      e_degen <= (sq_root[RootW] == '0) || (sq_car[RootW].s == '0);

      dv_d[0]     <= e_d;
      dv_degen[0] <= e_degen;
    end
  end

  for (genvar k = 0; k < RootW; k++) begin : g_sqrt
    localparam int Bit = RootW - 1 - k;
    logic [SqW:0] trial;
    assign trial = ((SqW + 1)'(sq_root[k]) << (Bit + 1)) | ((SqW + 1)'(1) << (2 * Bit));

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_valid[k+1] <= 1'b0;
      end else if (adv) begin
        sq_valid[k+1] <= sq_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_car[k+1] <= sq_car[k];
        if ({1'b0, sq_rem[k]} >= trial) begin
          sq_rem[k+1]  <= sq_rem[k] - SqW'(trial);
          sq_root[k+1] <= sq_root[k] | (RootW'(1) << Bit);
        end else begin
          sq_rem[k+1]  <= sq_rem[k];
          sq_root[k+1] <= sq_root[k];
        end
      end
    end
  end

  always_comb begin
    lane_neg[0] = e_car.dx[DiffW-1];
    lane_neg[1] = e_car.dy[DiffW-1];
    lane_neg[2] = e_car.p0[PW-1];
    lane_neg[3] = e_car.p1[PW-1];
    lane_neg[4] = e_car.p3[PW-1];
    lane_num[0] = e_car.dx[DiffW-1] ? NW'(-e_car.dx) : NW'(e_car.dx);
    lane_num[1] = e_car.dy[DiffW-1] ? NW'(-e_car.dy) : NW'(e_car.dy);
    lane_num[2] = e_car.p0[PW-1] ? NW'(-e_car.p0) : NW'(e_car.p0);
    lane_num[3] = e_car.p1[PW-1] ? NW'(-e_car.p1) : NW'(e_car.p1);
    lane_num[4] = e_car.p3[PW-1] ? NW'(-e_car.p3) : NW'(e_car.p3);
  end

  for (genvar l = 0; l < Lanes; l++) begin : g_prep
    localparam int F = (l < 2) ? AlongF : EdgeF;
    localparam int K = QW - F;

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[0][l] <= DW'(lane_num[l] >> K);
        dv_low[0][l] <= QW'({lane_num[l], {F{1'b0}}});
        dv_ovf[0][l] <= DW'(lane_num[l] >> K) >= e_d;
        dv_neg[0][l] <= lane_neg[l];
        dv_q[0][l]   <= '0;
      end
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[j+1] <= 1'b0;
      end else if (adv) begin
        dv_valid[j+1] <= dv_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_d[j+1]     <= dv_d[j];
        dv_degen[j+1] <= dv_degen[j];
      end
    end

    for (genvar l = 0; l < Lanes; l++) begin : g_lane
      logic [DW:0] trial;
      assign trial = {dv_rem[j][l], dv_low[j][l][QW-1]};

      always_ff @(posedge clk) begin
        if (adv) begin
          dv_low[j+1][l] <= {dv_low[j][l][QW-2:0], 1'b0};
          dv_ovf[j+1][l] <= dv_ovf[j][l];
          dv_neg[j+1][l] <= dv_neg[j][l];
          if (trial >= {1'b0, dv_d[j]}) begin
            dv_rem[j+1][l] <= DW'(trial - {1'b0, dv_d[j]});
            dv_q[j+1][l]   <= {dv_q[j][l][QW-2:0], 1'b1};
          end else begin
            dv_rem[j+1][l] <= DW'(trial);
            dv_q[j+1][l]   <= {dv_q[j][l][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      fin_mag[l] = (dv_ovf[QW][l] || dv_q[QW][l][QW-1]) ? MagCap : dv_q[QW][l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (outgo) begin
      m_axis_tvalid <= dv_valid[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (outgo && dv_valid[QW]) begin
      m_axis_tuser <= dv_degen[QW];
      if (dv_degen[QW]) begin
        m_axis_tdata <= '0;
      end else begin
        m_axis_tdata <= {lees_term(fin_mag[4], dv_neg[QW][4], 1'b1),
                         lees_term(fin_mag[2], !dv_neg[QW][2], 1'b1),
                         lees_term(fin_mag[3], dv_neg[QW][3], 1'b1),
                         lees_term(fin_mag[2], dv_neg[QW][2], 1'b1),
                         lees_term(fin_mag[1], dv_neg[QW][1], 1'b0),
                         lees_term(fin_mag[0], dv_neg[QW][0], 1'b0)};
      end
    end
  end

`ifndef SYNTH
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("degenerate result carries nonzero terms");

  a_sqrt_floor: assert property (@(posedge clk) disable iff (rst)
    sq_valid[RootW] |-> sq_rem[RootW] <= {sq_root[RootW], 1'b0})
    else $error("square root remainder exceeds floor bound");

  a_div_rem_along: assert property (@(posedge clk) disable iff (rst)
    dv_valid[QW] && !dv_degen[QW] && !dv_ovf[QW][0] |-> dv_rem[QW][0] < dv_d[QW])
    else $error("along-x divider remainder not below divisor");

  a_div_rem_edge: assert property (@(posedge clk) disable iff (rst)
    dv_valid[QW] && !dv_degen[QW] && !dv_ovf[QW][3] |-> dv_rem[QW][3] < dv_d[QW])
    else $error("edge divider remainder not below divisor");
`endif

endmodule
